// File: rtl/sht_pkg.sv
package sht_pkg;

    localparam int SLOTS     = 256;
    localparam int SLOT_AW   = $clog2(SLOTS);
    localparam int ENTRY_W   = 64;
    localparam int HASH_W    = 64;
    localparam int COUNT_W   = 9;
    localparam int HCNT_W    = $clog2(HASH_W);
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_POINTER_MODE = 1'd1;

    localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

    localparam logic [2:0] OP_SET_VALUE   = 3'd0;
    localparam logic [2:0] OP_SET_POINTER = 3'd1;
    localparam logic [2:0] OP_GET_VALUE   = 3'd2;
    localparam logic [2:0] OP_GET_POINTER = 3'd3;
    localparam logic [2:0] OP_FILL        = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_ACCESS,
        S_FILL,
        S_RESP
    } t_state;

endpackage

// File: rtl/string_hashed_slot_table.sv
// string-keyed slot table with a 64-bit polynomial hash (hash*97+byte)
// input: a transaction is taken on i_start while o_busy is low; one key byte
//   per transaction, i_key_last marks the final byte and carries the op
// a non-last byte hashes in the accepting cycle and leaves o_busy low, so
//   key bytes stream at one per cycle
// the last byte starts the op: the hash is reduced modulo the slot count by a
//   bit-serial restoring divider, one hash bit per cycle, then the slot is
//   written or read in S_ACCESS and the response formed in S_RESP
// get/set/unknown ops: S_DIV, S_ACCESS and S_RESP in that order, then the result
// fill: skips the divider, one slot written per cycle, slots 0 to count-1;
//   in pointer mode nothing is written and S_FILL goes straight to S_RESP
// result: o_valid is high for exactly one cycle with o_ok, o_value_out and
//   o_slot_index; the receiver cannot stall, results are never held
// config: i_cfg_we writes slot count (index 0) or pointer mode (index 1);
//   the user must write it only while idle, the block does not enforce this
// reset: synchronous, active low; clears the hash, the config to slot count
//   256 and value mode, and all slots to zero through per-slot valid bits
module string_hashed_slot_table
    import sht_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  logic [2:0]           i_op,
    input  logic [7:0]           i_key_byte,
    input  logic                 i_key_last,
    input  logic [ENTRY_W-1:0]   i_value_in,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COUNT_W-1:0]   i_cfg_data,
    output logic                 o_valid,
    output logic                 o_ok,
    output logic [ENTRY_W-1:0]   o_value_out,
    output logic [7:0]           o_slot_index
);

    t_state               r_state, n_state;
    logic [HASH_W-1:0]    r_hash, n_hash;
    logic [HASH_W-1:0]    r_shift;
    logic [COUNT_W-1:0]   r_rem;
    logic [HCNT_W-1:0]    r_bitcnt;
    logic [SLOT_AW-1:0]   r_cur;
    logic [2:0]           r_op;
    logic [ENTRY_W-1:0]   r_data;
    logic [COUNT_W-1:0]   r_slot_count;
    logic                 r_ptr_mode;
    logic [SLOTS-1:0]     r_slot_vld;
    logic [ENTRY_W-1:0]   r_mem [SLOTS];
    logic [ENTRY_W-1:0]   r_rd;
    logic                 r_rd_vld;
    logic                 r_valid;
    logic                 r_ok;
    logic [ENTRY_W-1:0]   r_value_out;
    logic [7:0]           r_slot_index;

    logic                 accept;
    logic                 fill_last;
    logic [COUNT_W-1:0]   eff_count;
    logic [COUNT_W-1:0]   rem_shift;
    logic [COUNT_W-1:0]   rem_next;
    logic                 mem_we;
    logic [SLOT_AW-1:0]   mem_addr;
    logic                 set_ok;
    logic                 resp_ok;
    logic [ENTRY_W-1:0]   resp_value;
    logic [ENTRY_W-1:0]   rd_value;

    assign accept = i_start && (r_state == S_IDLE);

    always_comb begin
        if (r_slot_count == '0) begin
            eff_count = COUNT_W'(1);
        end else if (r_slot_count > COUNT_W'(SLOTS)) begin
            eff_count = COUNT_W'(SLOTS);
        end else begin
            eff_count = r_slot_count;
        end
    end

    // hash*97 = hash*64 + hash*32 + hash
    always_comb begin
        if (i_key_byte != 8'd0) begin
            n_hash = (r_hash << 6) + (r_hash << 5) + r_hash
                   + {{(HASH_W-8){1'b0}}, i_key_byte};
        end else begin
            n_hash = r_hash;
        end
    end

    // restoring remainder step, one hash bit per cycle
    assign rem_shift = {r_rem[COUNT_W-2:0], r_shift[HASH_W-1]};
    assign rem_next  = (rem_shift >= eff_count) ? (rem_shift - eff_count) : rem_shift;

    assign fill_last = ({1'b0, r_cur} + COUNT_W'(1)) == eff_count;

    assign set_ok = ((r_op == OP_SET_VALUE) && !r_ptr_mode)
                 || ((r_op == OP_SET_POINTER) && r_ptr_mode);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_key_last) begin
                    n_state = (i_op == OP_FILL) ? S_FILL : S_DIV;
                end
            end
            S_DIV: begin
                if (r_bitcnt == HCNT_W'(HASH_W - 1)) begin
                    n_state = S_ACCESS;
                end
            end
            S_ACCESS: n_state = S_RESP;
            S_FILL: begin
                if (r_ptr_mode || fill_last) begin
                    n_state = S_RESP;
                end
            end
            S_RESP:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we   = 1'b0;
        mem_addr = r_rem[SLOT_AW-1:0];
        case (r_state)
            S_ACCESS: mem_we = set_ok;
            S_FILL: begin
                mem_we   = !r_ptr_mode;
                mem_addr = r_cur;
            end
            default: mem_we = 1'b0;
        endcase
    end

    assign rd_value = r_rd_vld ? r_rd : '0;

    always_comb begin
        resp_ok    = 1'b0;
        resp_value = '0;
        case (r_op)
            OP_SET_VALUE:   resp_ok = !r_ptr_mode;
            OP_SET_POINTER: resp_ok = r_ptr_mode;
            OP_GET_VALUE: begin
                if (!r_ptr_mode) begin
                    resp_ok    = 1'b1;
                    resp_value = rd_value;
                end
            end
            OP_GET_POINTER: begin
                if (r_ptr_mode) begin
                    resp_ok    = rd_value != '0;
                    resp_value = rd_value;
                end
            end
            OP_FILL: resp_ok = !r_ptr_mode;
            default: resp_ok = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_hash       <= '0;
            r_slot_count <= COUNT_RESET;
            r_ptr_mode   <= 1'b0;
            r_slot_vld   <= '0;
            r_valid      <= 1'b0;
            r_bitcnt     <= '0;
            r_cur        <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= r_state == S_RESP;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SLOT_COUNT:   r_slot_count <= i_cfg_data;
                    CFG_POINTER_MODE: r_ptr_mode   <= i_cfg_data[0];
                    default:          r_ptr_mode   <= r_ptr_mode;
                endcase
            end
            if (accept) begin
                r_hash   <= i_key_last ? '0 : n_hash;
                r_bitcnt <= '0;
                r_cur    <= '0;
            end
            if (r_state == S_DIV) begin
                r_bitcnt <= r_bitcnt + HCNT_W'(1);
            end
            if (r_state == S_FILL) begin
                r_cur <= r_cur + SLOT_AW'(1);
            end
            if (mem_we) begin
                r_slot_vld[mem_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_key_last) begin
            r_shift <= n_hash;
            r_rem   <= '0;
            r_op    <= i_op;
            r_data  <= i_value_in;
        end else if (r_state == S_DIV) begin
            r_shift <= r_shift << 1;
            r_rem   <= rem_next;
        end
        if (r_state == S_RESP) begin
            r_ok         <= resp_ok;
            r_value_out  <= resp_value;
            r_slot_index <= (r_op == OP_FILL) ? 8'd0 : 8'(r_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= r_data;
        end
        r_rd     <= r_mem[mem_addr];
        r_rd_vld <= r_slot_vld[mem_addr];
    end

    assign o_busy       = r_state != S_IDLE;
    assign o_valid      = r_valid;
    assign o_ok         = r_ok;
    assign o_value_out  = r_value_out;
    assign o_slot_index = r_slot_index;

endmodule

// File: rtl/sht_checker.sv
module sht_checker
    import sht_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               i_key_last,
    input logic               o_busy,
    input logic               o_valid,
    input logic               o_ok,
    input logic [ENTRY_W-1:0] o_value_out
);

    // results never come back to back
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_ok |-> o_value_out == '0)
        else $error("failed transaction returned nonzero data");

    a_key_byte_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && !i_key_last |=> !o_valid && !o_busy)
        else $error("non-final key byte produced a result or stalled");

    a_last_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy && i_key_last |=> o_busy)
        else $error("final key byte did not start an operation");

    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(o_busy))
        else $error("result without a preceding operation");

endmodule

bind string_hashed_slot_table sht_checker u_sht_checker (.*);

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import sht_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 400;
    localparam int DIR_N         = 31;

    localparam logic [2:0] OP_RSVD_5 = 3'd5;
    localparam logic [2:0] OP_RSVD_6 = 3'd6;
    localparam logic [2:0] OP_RSVD_7 = 3'd7;

    typedef struct packed {
        logic               ok;
        logic [ENTRY_W-1:0] value;
        logic [7:0]         slot;
    } t_slot_reply;

    typedef enum logic [1:0] {
        R_ITEM,
        R_SLOTS,
        R_MODE
    } t_row_kind;

    typedef struct packed {
        t_row_kind          kind;
        logic [2:0]         op;
        logic [7:0]         key;
        logic               last;
        logic [ENTRY_W-1:0] din;
        logic               chk;
        logic               want_ok;
        logic [ENTRY_W-1:0] want_val;
        logic [7:0]         want_slot;
    } t_dir_row;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic [2:0]           i_op;
    logic [7:0]           i_key_byte;
    logic                 i_key_last;
    logic [ENTRY_W-1:0]   i_value_in;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [COUNT_W-1:0]   i_cfg_data;
    logic                 o_valid;
    logic                 o_ok;
    logic [ENTRY_W-1:0]   o_value_out;
    logic [7:0]           o_slot_index;

    // predicted block state
    logic [63:0]          hash_acc;
    logic [ENTRY_W-1:0]   slot_mem [SLOTS];
    logic [COUNT_W-1:0]   cfg_slots;
    logic                 cfg_ptr_mode;

    t_slot_reply          pending_replies [$];
    t_slot_reply          arrived_want;
    int                   mismatch_count = 0;
    int                   items_sent;
    int                   idle_cycles = 0;
    bit                   no_idle;

    t_dir_row dir_rows [DIR_N] = '{
        '{R_ITEM, OP_GET_VALUE, 8'h41, 1'b1, 64'h0, 1'b1, 1'b1, 64'h0, 8'd65},
        '{R_ITEM, OP_SET_VALUE, 8'hFF, 1'b1, '1, 1'b1, 1'b1, 64'h0, 8'd255},
        '{R_ITEM, OP_GET_VALUE, 8'hFF, 1'b1, 64'h0, 1'b1, 1'b1, '1, 8'd255},
        '{R_ITEM, OP_GET_VALUE, 8'h00, 1'b1, 64'h0, 1'b1, 1'b1, 64'h0, 8'd0},
        '{R_ITEM, OP_SET_VALUE, 8'h61, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 8'd0},
        '{R_ITEM, OP_SET_VALUE, 8'h00, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 8'd0},
        '{R_ITEM, OP_SET_VALUE, 8'h62, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0, 64'h0, 8'd0},
        '{R_ITEM, OP_GET_VALUE, 8'h61, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 8'd0},
        '{R_ITEM, OP_GET_VALUE, 8'h62, 1'b1, 64'h0, 1'b0, 1'b0, 64'h0, 8'd0},
        '{R_ITEM, OP_SET_POINTER, 8'h01, 1'b1, '1, 1'b1, 1'b0, 64'h0, 8'd1},
        '{R_ITEM, OP_GET_POINTER, 8'h01, 1'b1, 64'h0, 1'b1, 1'b0, 64'h0, 8'd1},
        '{R_ITEM, OP_RSVD_5, 8'h10, 1'b1, '1, 1'b1, 1'b0, 64'h0, 8'd16},
        '{R_ITEM, OP_RSVD_7, 8'h10, 1'b1, '1, 1'b1, 1'b0, 64'h0, 8'd16},
        '{R_ITEM, OP_FILL, 8'h33, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1, 1'b1, 64'h0, 8'd0},
        '{R_ITEM, OP_GET_VALUE, 8'h80, 1'b1, 64'h0, 1'b1, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5, 8'd128},
        '{R_ITEM, OP_GET_VALUE, 8'hFF, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 8'd0},
        '{R_ITEM, OP_GET_VALUE, 8'hFF, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 8'd0},
        '{R_ITEM, OP_GET_VALUE, 8'hFF, 1'b1, 64'h0, 1'b0, 1'b0, 64'h0, 8'd0},
        '{R_MODE, OP_SET_VALUE, 8'h00, 1'b0, 64'h1, 1'b0, 1'b0, 64'h0, 8'd0},
        '{R_ITEM, OP_SET_POINTER, 8'h41, 1'b1, 64'h0, 1'b1, 1'b1, 64'h0, 8'd65},
        '{R_ITEM, OP_GET_POINTER, 8'h41, 1'b1, 64'h0, 1'b1, 1'b0, 64'h0, 8'd65},
        '{R_ITEM, OP_SET_POINTER, 8'h42, 1'b1, 64'h8000_0000_0000_0001, 1'b1, 1'b1, 64'h0, 8'd66},
        '{R_ITEM, OP_GET_POINTER, 8'h42, 1'b1, 64'h0, 1'b1, 1'b1, 64'h8000_0000_0000_0001, 8'd66},
        '{R_ITEM, OP_FILL, 8'h00, 1'b1, '1, 1'b1, 1'b0, 64'h0, 8'd0},
        '{R_ITEM, OP_GET_VALUE, 8'h42, 1'b1, 64'h0, 1'b1, 1'b0, 64'h0, 8'd66},
        '{R_SLOTS, OP_SET_VALUE, 8'h00, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 8'd0},
        '{R_ITEM, OP_GET_POINTER, 8'h42, 1'b1, 64'h0, 1'b1, 1'b1, 64'hA5A5_A5A5_A5A5_A5A5, 8'd0},
        '{R_SLOTS, OP_SET_VALUE, 8'h00, 1'b0, 64'd511, 1'b0, 1'b0, 64'h0, 8'd0},
        '{R_ITEM, OP_GET_POINTER, 8'h42, 1'b1, 64'h0, 1'b1, 1'b1, 64'h8000_0000_0000_0001, 8'd66},
        '{R_SLOTS, OP_SET_VALUE, 8'h00, 1'b0, 64'd3, 1'b0, 1'b0, 64'h0, 8'd0},
        '{R_MODE, OP_SET_VALUE, 8'h00, 1'b0, 64'h0, 1'b0, 1'b0, 64'h0, 8'd0}
    };

    string_hashed_slot_table dut (.*);

    initial begin
        i_clk = 1'b0;
    end

    always #4 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("[%0t] %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic table_step(input logic [2:0] op, input logic [7:0] key, input logic last,
                              input logic [ENTRY_W-1:0] din, output bit produced,
                              output t_slot_reply r);
        int unsigned cnt;
        int unsigned slot;
        produced = 1'b0;
        r = '0;
        if (key != 8'h00)
            hash_acc = hash_acc * 64'd97 + 64'(key);
        if (!last)
            return;
        cnt = (cfg_slots == 0) ? 1 : ((cfg_slots > SLOTS) ? SLOTS : int'(cfg_slots));
        slot = int'(hash_acc % 64'(cnt));
        hash_acc = '0;
        produced = 1'b1;
        case (op)
            OP_SET_VALUE: begin
                if (!cfg_ptr_mode) begin
                    slot_mem[slot] = din;
                    r.ok = 1'b1;
                end
            end
            OP_SET_POINTER: begin
                if (cfg_ptr_mode) begin
                    slot_mem[slot] = din;
                    r.ok = 1'b1;
                end
            end
            OP_GET_VALUE: begin
                if (!cfg_ptr_mode) begin
                    r.value = slot_mem[slot];
                    r.ok = 1'b1;
                end
            end
            OP_GET_POINTER: begin
                if (cfg_ptr_mode) begin
                    r.value = slot_mem[slot];
                    r.ok = (r.value != '0);
                end
            end
            OP_FILL: begin
                slot = 0;
                if (!cfg_ptr_mode) begin
                    for (int i = 0; i < int'(cnt); i++)
                        slot_mem[i] = din;
                    r.ok = 1'b1;
                end
            end
            default: ;
        endcase
        r.slot = 8'(slot);
    endtask

    function automatic int draw_gap();
        return no_idle ? 0 : int'($urandom_range(0, 5));
    endfunction

    task automatic send_item(input logic [2:0] op, input logic [7:0] key, input logic last,
                             input logic [ENTRY_W-1:0] din, input bit typed,
                             input t_slot_reply typed_reply);
        bit produced;
        t_slot_reply r;
        int gap;
        if (!i_start)
            i_start <= 1'b1;
        i_op       <= op;
        i_key_byte <= key;
        i_key_last <= last;
        i_value_in <= din;
        do @(posedge i_clk); while (o_busy);
        table_step(op, key, last, din, produced, r);
        if (produced)
            pending_replies.push_back(typed ? typed_reply : r);
        items_sent++;
        gap = draw_gap();
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_replies_drained();
        if (i_start)
            i_start <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy)
            @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        if (idx == CFG_SLOT_COUNT)
            cfg_slots = data;
        else
            cfg_ptr_mode = data[0];
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [2:0] pick_op();
        int unsigned r;
        r = $urandom_range(0, 19);
        if (r <= 6)
            return cfg_ptr_mode ? OP_SET_POINTER : OP_SET_VALUE;
        else if (r <= 13)
            return cfg_ptr_mode ? OP_GET_POINTER : OP_GET_VALUE;
        else if (r == 14)
            return OP_FILL;
        else if (r == 15)
            return cfg_ptr_mode ? OP_SET_VALUE : OP_SET_POINTER;
        else if (r == 16)
            return cfg_ptr_mode ? OP_GET_VALUE : OP_GET_POINTER;
        else if (r == 17)
            return ($urandom_range(0, 1) == 0) ? OP_RSVD_6 : OP_RSVD_7;
        return 3'($urandom_range(0, 7));
    endfunction

    function automatic logic [ENTRY_W-1:0] pick_value();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return {$urandom, $urandom};
    endfunction

    function automatic logic [7:0] pick_key_byte();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r <= 2)
            return 8'($urandom_range(0, 255));
        return 8'h61 + 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [COUNT_W-1:0] pick_slot_count();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return COUNT_W'(1);
            2: return COUNT_W'($urandom_range(2, 16));
            3: return COUNT_W'($urandom_range(17, 256));
            4: return COUNT_W'(SLOTS);
            default: return COUNT_W'($urandom_range(257, 511));
        endcase
    endfunction

    // one key: a few bytes with noise ops, the last one carries the real op
    task automatic send_random_key();
        int len;
        t_slot_reply none;
        none = '0;
        len = $urandom_range(1, 4);
        for (int b = 0; b < len; b++) begin
            if (b == len - 1)
                send_item(pick_op(), pick_key_byte(), 1'b1, pick_value(), 1'b0, none);
            else
                send_item(3'($urandom_range(0, 7)), pick_key_byte(), 1'b0, pick_value(),
                          1'b0, none);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (pending_replies.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction, slot %0d", o_slot_index));
            end else begin
                arrived_want = pending_replies.pop_front();
                if (o_ok !== arrived_want.ok)
                    report_mismatch($sformatf("ok: got %b want %b", o_ok, arrived_want.ok));
                if (o_value_out !== arrived_want.value)
                    report_mismatch($sformatf("value: got %h want %h",
                                              o_value_out, arrived_want.value));
                if (o_slot_index !== arrived_want.slot)
                    report_mismatch($sformatf("slot: got %0d want %0d",
                                              o_slot_index, arrived_want.slot));
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid || i_cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial begin
        t_slot_reply want;
        int rand_target;
        int phase;
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_op           = OP_SET_VALUE;
        i_key_byte     = '0;
        i_key_last     = 1'b0;
        i_value_in     = '0;
        i_cfg_we       = 1'b0;
        i_cfg_idx      = CFG_SLOT_COUNT;
        i_cfg_data     = '0;
        hash_acc       = '0;
        cfg_slots      = COUNT_RESET;
        cfg_ptr_mode   = 1'b0;
        items_sent     = 0;
        no_idle        = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            slot_mem[i] = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            case (dir_rows[n].kind)
                R_ITEM: begin
                    want.ok    = dir_rows[n].want_ok;
                    want.value = dir_rows[n].want_val;
                    want.slot  = dir_rows[n].want_slot;
                    send_item(dir_rows[n].op, dir_rows[n].key, dir_rows[n].last,
                              dir_rows[n].din, dir_rows[n].chk, want);
                end
                R_SLOTS: begin
                    wait_replies_drained();
                    write_cfg(CFG_SLOT_COUNT, dir_rows[n].din[COUNT_W-1:0]);
                end
                default: begin
                    wait_replies_drained();
                    write_cfg(CFG_POINTER_MODE, dir_rows[n].din[COUNT_W-1:0]);
                end
            endcase
        end

        rand_target = items_sent + RANDOM_ITEMS;
        phase = 0;
        while (items_sent < rand_target) begin
            wait_replies_drained();
            write_cfg(CFG_SLOT_COUNT, pick_slot_count());
            write_cfg(CFG_POINTER_MODE, COUNT_W'($urandom_range(0, 1)));
            no_idle = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < 20 && items_sent < rand_target; k++) begin
                // in phase 1, after ten keys, hold the sender until the block has answered everything
                if (phase == 1 && k == 10)
                    wait_replies_drained();
                send_random_key();
            end
            phase++;
        end

        wait_replies_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/sht_pkg.sv
rtl/string_hashed_slot_table.sv
rtl/sht_checker.sv
tb/testbench.sv
